### src/lpr_pkg.sv
// shared types, constants and helpers of the line pixel rasterizer
package lpr_pkg;

    localparam int COORD_BITS     = 8;
    localparam int ERR_BITS       = COORD_BITS + 2;
    localparam int CALC_BITS      = COORD_BITS + 3;
    localparam int CFG_BITS       = 9;
    localparam int CFG_INDEX_BITS = 1;
    localparam int PAGE_BITS      = 5;
    localparam int MASK_BITS      = 8;
    localparam int CLIP_BITS      = COORD_BITS + CFG_BITS;

    localparam int IN_RAW_BITS    = 4 * COORD_BITS;
    localparam int IN_DATA_BITS   = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS   = 1 + 2 * COORD_BITS + PAGE_BITS + MASK_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0]  WIDTH_RESET  = 9'd128;
    localparam logic [CFG_BITS-1:0]  HEIGHT_RESET = 9'd64;
    localparam logic [MASK_BITS-1:0] MASK_TOP     = 8'h80;
    localparam logic [2:0]           ROW_IN_PAGE  = 3'h7;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic   kind;
        coord_t x_first;
        coord_t y_first;
        coord_t x_final;
        coord_t y_final;
    } item_t;

    typedef struct packed {
        logic                 pixel_valid;
        coord_t               pixel_x;
        coord_t               pixel_y;
        logic [PAGE_BITS-1:0] page_index;
        logic [MASK_BITS-1:0] bit_mask;
        logic                 last;
        logic                 idle;
    } result_t;

    function automatic logic [PAGE_BITS-1:0] page_of(input coord_t y);
        logic [COORD_BITS+PAGE_BITS-1:0] wide;
        wide = {{PAGE_BITS{1'b0}}, y};
        return wide[PAGE_BITS+2:3];
    endfunction

    function automatic logic [MASK_BITS-1:0] mask_of(input coord_t y);
        return MASK_TOP >> (y[2:0] & ROW_IN_PAGE);
    endfunction

endpackage

### src/line_pixel_rasterizer.sv
// top level of the line pixel rasterizer: config registers, front queue and walker
//
//  channel   dir  handshake            contents
//  s_*       in   s_tvalid / s_tready  start or step word, kind in s_tuser
//  m_*       out  m_tvalid / m_tready  one pixel word per input word
//  cfg_*     in   cfg_we               display width and height
//
//  one word in and one word out per cycle sustained while the output is not stalled; a word passes
//  the queue stage, then the walker output register; a walk step is two compares, each with an add
//  reset gives width 128, height 64, no line active and an empty queue
//  a stalled output holds the walker, the two-entry queue keeps taking words until full
module line_pixel_rasterizer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lpr_pkg::IN_DATA_BITS-1:0]     s_tdata,   // x_first, y_first, x_final, y_final
    input  logic                                 s_tuser,   // kind
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lpr_pkg::OUT_DATA_BITS-1:0]    m_tdata,   // pixel_valid, pixel_x, pixel_y, page_index, bit_mask
    output logic                                 m_tuser,   // idle
    output logic                                 m_tlast,
    input  logic                                 cfg_we,
    input  logic [lpr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [lpr_pkg::CFG_BITS-1:0]         cfg_data
);

    logic [lpr_pkg::CFG_BITS-1:0] width_reg;
    logic [lpr_pkg::CFG_BITS-1:0] height_reg;
    logic                         head_valid;
    lpr_pkg::item_t               head_item;
    logic                         head_pop;
    lpr_pkg::result_t             out_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lpr_pkg::WIDTH_RESET;
            height_reg <= lpr_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpr_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                lpr_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    lpr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop)
    );

    lpr_walker u_walker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_item      (head_item),
        .head_pop       (head_pop),
        .display_width  (width_reg),
        .display_height (height_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_word       (out_word)
    );

    assign m_tdata = lpr_pkg::OUT_DATA_BITS'({out_word.bit_mask, out_word.page_index,
                                              out_word.pixel_y, out_word.pixel_x,
                                              out_word.pixel_valid});
    assign m_tuser = out_word.idle;
    assign m_tlast = out_word.last;

endmodule

### src/lpr_front.sv
// input side: accepts words, decodes them and holds them in a short queue
module lpr_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lpr_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input  logic                              s_tuser,
    output logic                              head_valid,
    output lpr_pkg::item_t                    head_item,
    input  logic                              head_pop
);

    lpr_pkg::item_t                     queue_mem [lpr_pkg::QUEUE_DEPTH];
    logic [lpr_pkg::QPTR_BITS-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [lpr_pkg::QPTR_BITS-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [lpr_pkg::QCNT_BITS-1:0]      count_reg, count_next;
    lpr_pkg::item_t                     in_item;
    logic                               push;
    logic                               pop;

    assign s_tready   = (count_reg != lpr_pkg::QCNT_BITS'(lpr_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign push       = s_tvalid && s_tready;
    assign pop        = head_pop && head_valid;
    assign head_item  = queue_mem[rd_ptr_reg];

    // field order in tdata: x_first, y_first, x_final, y_final
    always_comb
    begin
        in_item.kind    = s_tuser;
        in_item.x_first = s_tdata[lpr_pkg::COORD_BITS-1:0];
        in_item.y_first = s_tdata[2*lpr_pkg::COORD_BITS-1:lpr_pkg::COORD_BITS];
        in_item.x_final = s_tdata[3*lpr_pkg::COORD_BITS-1:2*lpr_pkg::COORD_BITS];
        in_item.y_final = s_tdata[4*lpr_pkg::COORD_BITS-1:3*lpr_pkg::COORD_BITS];
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == lpr_pkg::QPTR_BITS'(lpr_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            if (rd_ptr_reg == lpr_pkg::QPTR_BITS'(lpr_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= in_item;
    end

endmodule

### src/lpr_walker.sv
// back side: bresenham walk, clipping, page and mask, output register
module lpr_walker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           head_valid,
    input  lpr_pkg::item_t                 head_item,
    output logic                           head_pop,
    input  logic [lpr_pkg::CFG_BITS-1:0]   display_width,
    input  logic [lpr_pkg::CFG_BITS-1:0]   display_height,
    output logic                           out_valid,
    input  logic                           out_ready,
    output lpr_pkg::result_t               out_word
);

    logic                                 active_reg, active_next;
    lpr_pkg::coord_t                      cur_x_reg, cur_x_next;
    lpr_pkg::coord_t                      cur_y_reg, cur_y_next;
    lpr_pkg::coord_t                      end_x_reg, end_x_next;
    lpr_pkg::coord_t                      end_y_reg, end_y_next;
    lpr_pkg::coord_t                      delta_x_reg, delta_x_next;
    lpr_pkg::coord_t                      delta_y_reg, delta_y_next;
    logic                                 x_dec_reg, x_dec_next;
    logic                                 y_dec_reg, y_dec_next;
    logic signed [lpr_pkg::ERR_BITS-1:0]  err_reg, err_next;
    logic                                 out_valid_reg;
    lpr_pkg::result_t                     out_reg, res;

    logic                                 take;
    logic signed [lpr_pkg::CALC_BITS-1:0] twice, dx_s, dy_s, err_calc;
    logic                                 done;

    assign take      = head_valid && (!out_valid_reg || out_ready);
    assign head_pop  = take;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_comb
    begin
        active_next  = active_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        end_x_next   = end_x_reg;
        end_y_next   = end_y_reg;
        delta_x_next = delta_x_reg;
        delta_y_next = delta_y_reg;
        x_dec_next   = x_dec_reg;
        y_dec_next   = y_dec_reg;
        err_next     = err_reg;
        twice        = '0;
        dx_s         = '0;
        dy_s         = '0;
        err_calc     = '0;
        done         = 1'b0;
        res          = '0;

        if (head_item.kind == lpr_pkg::KIND_START)
        begin
            cur_x_next   = head_item.x_first;
            cur_y_next   = head_item.y_first;
            end_x_next   = head_item.x_final;
            end_y_next   = head_item.y_final;
            x_dec_next   = head_item.x_final < head_item.x_first;
            y_dec_next   = head_item.y_final < head_item.y_first;
            delta_x_next = x_dec_next ? head_item.x_first - head_item.x_final
                                      : head_item.x_final - head_item.x_first;
            delta_y_next = y_dec_next ? head_item.y_first - head_item.y_final
                                      : head_item.y_final - head_item.y_first;
            dx_s         = $signed({3'b000, delta_x_next});
            dy_s         = $signed({3'b000, delta_y_next});
            err_calc     = dx_s - dy_s;
            err_next     = err_calc[lpr_pkg::ERR_BITS-1:0];
            active_next  = 1'b1;
        end
        else if (active_reg)
        begin
            dx_s     = $signed({3'b000, delta_x_reg});
            dy_s     = $signed({3'b000, delta_y_reg});
            twice    = $signed({err_reg, 1'b0});
            err_calc = $signed({err_reg[lpr_pkg::ERR_BITS-1], err_reg});
            if (twice > -dy_s)
            begin
                err_calc   = err_calc - dy_s;
                cur_x_next = x_dec_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
            end
            if (twice < dx_s)
            begin
                err_calc   = err_calc + dx_s;
                cur_y_next = y_dec_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            end
            err_next = err_calc[lpr_pkg::ERR_BITS-1:0];
        end

        if (head_item.kind == lpr_pkg::KIND_STEP && !active_reg)
        begin
            res.idle = 1'b1;
        end
        else
        begin
            done            = (cur_x_next == end_x_next) && (cur_y_next == end_y_next);
            res.pixel_valid =
                ({{lpr_pkg::CFG_BITS{1'b0}}, cur_x_next}
                    < {{lpr_pkg::COORD_BITS{1'b0}}, display_width})
                && ({{lpr_pkg::CFG_BITS{1'b0}}, cur_y_next}
                    < {{lpr_pkg::COORD_BITS{1'b0}}, display_height});
            res.pixel_x     = cur_x_next;
            res.pixel_y     = cur_y_next;
            res.page_index  = lpr_pkg::page_of(cur_y_next);
            res.bit_mask    = lpr_pkg::mask_of(cur_y_next);
            res.last        = done;
            if (done)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            end_x_reg     <= '0;
            end_y_reg     <= '0;
            delta_x_reg   <= '0;
            delta_y_reg   <= '0;
            x_dec_reg     <= 1'b0;
            y_dec_reg     <= 1'b0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                active_reg    <= active_next;
                cur_x_reg     <= cur_x_next;
                cur_y_reg     <= cur_y_next;
                end_x_reg     <= end_x_next;
                end_y_reg     <= end_y_next;
                delta_x_reg   <= delta_x_next;
                delta_y_reg   <= delta_y_next;
                x_dec_reg     <= x_dec_next;
                y_dec_reg     <= y_dec_next;
                err_reg       <= err_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= res;
    end

endmodule

### tb/sv/tb_line_pixel_rasterizer.sv
// testbench of the line pixel rasterizer: directed table, random line walks, predictor check
module tb_line_pixel_rasterizer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GAP_MAX     = 11;
    localparam int PHASE_ITEMS = 140;
    localparam int N_PHASES    = 8;
    localparam int N_DIRECTED  = 20;
    localparam int COORD_MAX   = (1 << lpr_pkg::COORD_BITS) - 1;

    localparam int X_LO    = 1;
    localparam int Y_LO    = X_LO + lpr_pkg::COORD_BITS;
    localparam int PAGE_LO = Y_LO + lpr_pkg::COORD_BITS;
    localparam int MASK_LO = PAGE_LO + lpr_pkg::PAGE_BITS;

    typedef struct packed {
        logic             kind;
        lpr_pkg::coord_t  x0;
        lpr_pkg::coord_t  y0;
        lpr_pkg::coord_t  x1;
        lpr_pkg::coord_t  y1;
        logic             typed;
        lpr_pkg::result_t want;
    } stim_row_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [lpr_pkg::IN_DATA_BITS-1:0]    s_tdata;   // x_first, y_first, x_final, y_final
    logic                                s_tuser;   // kind
    logic                                m_tvalid;
    logic                                m_tready;
    logic [lpr_pkg::OUT_DATA_BITS-1:0]   m_tdata;   // pixel_valid, pixel_x, pixel_y, page_index, bit_mask
    logic                                m_tuser;   // idle
    logic                                m_tlast;
    logic                                cfg_we;
    logic [lpr_pkg::CFG_INDEX_BITS-1:0]  cfg_index;
    logic [lpr_pkg::CFG_BITS-1:0]        cfg_data;

    line_pixel_rasterizer uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5ns clk = ~clk;

    // walker copy kept by the testbench
    logic                                  walk_on;
    lpr_pkg::coord_t                       px;
    lpr_pkg::coord_t                       py;
    lpr_pkg::coord_t                       ex;
    lpr_pkg::coord_t                       ey;
    lpr_pkg::coord_t                       span_x;
    lpr_pkg::coord_t                       span_y;
    logic                                  x_back;
    logic                                  y_back;
    logic signed [lpr_pkg::ERR_BITS-1:0]   err_acc;
    logic [lpr_pkg::CFG_BITS-1:0]          width_reg;
    logic [lpr_pkg::CFG_BITS-1:0]          height_reg;

    lpr_pkg::result_t pixel_expect_q[$];
    int      mismatch_count = 0;
    int      items_sent = 0;
    logic    src_calm = 1'b0;
    logic    sink_calm = 1'b0;

    stim_row_t directed_rows [0:N_DIRECTED-1] = '{
        '{lpr_pkg::KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1,
          '{1'b0, 8'd0,   8'd0,   5'd0,  8'h00, 1'b0, 1'b1}},
        '{lpr_pkg::KIND_START, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1,
          '{1'b1, 8'd0,   8'd0,   5'd0,  8'h80, 1'b1, 1'b0}},
        '{lpr_pkg::KIND_START, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1,
          '{1'b0, 8'd255, 8'd255, 5'd31, 8'h01, 1'b1, 1'b0}},
        '{lpr_pkg::KIND_STEP,  8'd255, 8'd255, 8'd255, 8'd255, 1'b1,
          '{1'b0, 8'd0,   8'd0,   5'd0,  8'h00, 1'b0, 1'b1}},
        '{lpr_pkg::KIND_START, 8'd0,   8'd0,   8'd2,   8'd0,   1'b0, '0},
        '{lpr_pkg::KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{lpr_pkg::KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{lpr_pkg::KIND_START, 8'd10,  8'd66,  8'd10,  8'd63,  1'b0, '0},
        '{lpr_pkg::KIND_STEP,  8'd170, 8'd85,  8'd170, 8'd85,  1'b0, '0},
        '{lpr_pkg::KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{lpr_pkg::KIND_STEP,  8'd85,  8'd170, 8'd85,  8'd170, 1'b0, '0},
        '{lpr_pkg::KIND_START, 8'd255, 8'd0,   8'd253, 8'd2,   1'b0, '0},
        '{lpr_pkg::KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{lpr_pkg::KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{lpr_pkg::KIND_START, 8'd0,   8'd0,   8'd100, 8'd50,  1'b0, '0},
        '{lpr_pkg::KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{lpr_pkg::KIND_START, 8'd7,   8'd7,   8'd8,   8'd9,   1'b0, '0},
        '{lpr_pkg::KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{lpr_pkg::KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{lpr_pkg::KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1,
          '{1'b0, 8'd0,   8'd0,   5'd0,  8'h00, 1'b0, 1'b1}}
    };

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic predict_pixel(input lpr_pkg::item_t w, output lpr_pkg::result_t r);
        int twice;
        int dx;
        int dy;
        r = '0;
        if (w.kind == lpr_pkg::KIND_START) begin
            px      = w.x_first;
            py      = w.y_first;
            ex      = w.x_final;
            ey      = w.y_final;
            x_back  = w.x_final < w.x_first;
            y_back  = w.y_final < w.y_first;
            span_x  = x_back ? w.x_first - w.x_final : w.x_final - w.x_first;
            span_y  = y_back ? w.y_first - w.y_final : w.y_final - w.y_first;
            err_acc = lpr_pkg::ERR_BITS'(int'(span_x) - int'(span_y));
            walk_on = 1'b1;
        end
        else if (!walk_on) begin
            r.idle = 1'b1;
            return;
        end
        else begin
            twice = 2 * int'(err_acc);
            dx    = int'(span_x);
            dy    = int'(span_y);
            if (twice > -dy) begin
                err_acc = lpr_pkg::ERR_BITS'(int'(err_acc) - dy);
                px      = x_back ? px - 1'b1 : px + 1'b1;
            end
            if (twice < dx) begin
                err_acc = lpr_pkg::ERR_BITS'(int'(err_acc) + dx);
                py      = y_back ? py - 1'b1 : py + 1'b1;
            end
        end
        r.pixel_valid = ({1'b0, px} < width_reg) && ({1'b0, py} < height_reg);
        r.pixel_x     = px;
        r.pixel_y     = py;
        r.page_index  = py[lpr_pkg::COORD_BITS-1:3];
        r.bit_mask    = lpr_pkg::MASK_TOP >> py[2:0];
        r.last        = (px == ex) && (py == ey);
        if (r.last)
            walk_on = 1'b0;
    endtask

    task automatic send_word(input logic kind, input logic [lpr_pkg::IN_DATA_BITS-1:0] data,
                             input logic typed, input lpr_pkg::result_t want);
        lpr_pkg::item_t   w;
        lpr_pkg::result_t r;
        int               gap;
        gap = src_calm ? 0 : $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 29) == 0)
            src_calm = !src_calm;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        w.kind    = kind;
        w.x_first = data[lpr_pkg::COORD_BITS-1:0];
        w.y_first = data[2*lpr_pkg::COORD_BITS-1:lpr_pkg::COORD_BITS];
        w.x_final = data[3*lpr_pkg::COORD_BITS-1:2*lpr_pkg::COORD_BITS];
        w.y_final = data[4*lpr_pkg::COORD_BITS-1:3*lpr_pkg::COORD_BITS];
        predict_pixel(w, r);
        pixel_expect_q.push_back(typed ? want : r);
        if (!r.idle)
            items_sent++;
    endtask

    task automatic send_random(input logic kind);
        send_word(kind, lpr_pkg::IN_DATA_BITS'($urandom), 1'b0, '0);
    endtask

    task automatic drain_pixels();
        s_tvalid <= 1'b0;
        while (pixel_expect_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_display_size(input logic [lpr_pkg::CFG_BITS-1:0] w,
                                      input logic [lpr_pkg::CFG_BITS-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= lpr_pkg::REG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        width_reg = w;
        cfg_index <= lpr_pkg::REG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        height_reg = h;
        cfg_we <= 1'b0;
    endtask

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    task automatic random_line();
        int x0;
        int y0;
        int x1;
        int y1;
        int n;
        int mode;
        x0   = $urandom_range(0, COORD_MAX);
        y0   = $urandom_range(0, COORD_MAX);
        mode = $urandom_range(0, 99);
        if (mode < 4) begin
            x1 = $urandom_range(0, COORD_MAX);
            y1 = $urandom_range(0, COORD_MAX);
        end
        else begin
            x1 = clamp_coord(x0 + int'($urandom_range(0, 24)) - 12);
            y1 = clamp_coord(y0 + int'($urandom_range(0, 24)) - 12);
        end
        n = (x1 > x0) ? x1 - x0 : x0 - x1;
        if (((y1 > y0) ? y1 - y0 : y0 - y1) > n)
            n = (y1 > y0) ? y1 - y0 : y0 - y1;
        // cut short, the next start drops the line
        if (mode >= 4 && mode < 14 && n > 0)
            n = $urandom_range(0, n - 1);
        // run past the end point into idle steps
        if (mode >= 90)
            n = n + $urandom_range(1, 2);
        send_word(lpr_pkg::KIND_START,
                  {y1[lpr_pkg::COORD_BITS-1:0], x1[lpr_pkg::COORD_BITS-1:0],
                   y0[lpr_pkg::COORD_BITS-1:0], x0[lpr_pkg::COORD_BITS-1:0]}, 1'b0, '0);
        repeat (n) send_random(lpr_pkg::KIND_STEP);
    endtask

    always @(posedge clk) begin : pixel_check
        lpr_pkg::result_t due;
        if (rst_n && m_tvalid && m_tready) begin
            if (pixel_expect_q.size() == 0) begin
                flag_mismatch("pixel word with nothing expected");
            end
            else begin
                due = pixel_expect_q.pop_front();
                compare_field("pixel_valid", m_tdata[0], due.pixel_valid);
                compare_field("pixel_x", m_tdata[X_LO +: lpr_pkg::COORD_BITS], due.pixel_x);
                compare_field("pixel_y", m_tdata[Y_LO +: lpr_pkg::COORD_BITS], due.pixel_y);
                compare_field("page_index", m_tdata[PAGE_LO +: lpr_pkg::PAGE_BITS],
                              due.page_index);
                compare_field("bit_mask", m_tdata[MASK_LO +: lpr_pkg::MASK_BITS],
                              due.bit_mask);
                compare_field("tdata padding",
                              m_tdata[lpr_pkg::OUT_DATA_BITS-1:lpr_pkg::OUT_RAW_BITS], 0);
                compare_field("last", m_tlast, due.last);
                compare_field("idle", m_tuser, due.idle);
            end
        end
    end

    initial begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, GAP_MAX);
            if ($urandom_range(0, 29) == 0)
                sink_calm = !sink_calm;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial begin
        logic [lpr_pkg::CFG_BITS-1:0] phase_w [0:N_PHASES-1];
        logic [lpr_pkg::CFG_BITS-1:0] phase_h [0:N_PHASES-1];
        int                           target;
        int                           pick;
        phase_w = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd0,   9'd37,  9'd128, 9'd200};
        phase_h = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd200, 9'd511, 9'd64,  9'd40};
        phase_w[N_PHASES-1] = lpr_pkg::CFG_BITS'($urandom_range(1, 256));
        phase_h[N_PHASES-1] = lpr_pkg::CFG_BITS'($urandom_range(1, 256));
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = lpr_pkg::KIND_START;
        cfg_we     = 1'b0;
        cfg_index  = lpr_pkg::REG_WIDTH;
        cfg_data   = '0;
        width_reg  = lpr_pkg::WIDTH_RESET;
        height_reg = lpr_pkg::HEIGHT_RESET;
        walk_on    = 1'b0;
        px         = '0;
        py         = '0;
        ex         = '0;
        ey         = '0;
        span_x     = '0;
        span_y     = '0;
        x_back     = 1'b0;
        y_back     = 1'b0;
        err_acc    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].kind,
                      {directed_rows[i].y1, directed_rows[i].x1,
                       directed_rows[i].y0, directed_rows[i].x0},
                      directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_pixels();
            write_display_size(phase_w[ph], phase_h[ph]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    send_random(lpr_pkg::KIND_STEP);
                else if (pick < 5)
                    send_random(lpr_pkg::KIND_START);
                else if (pick == 5)
                    drain_pixels();
                else
                    random_line();
            end
        end

        drain_pixels();
        repeat (10) @(posedge clk);
        while (pixel_expect_q.size() != 0) begin
            flag_mismatch("expected pixel word never arrived");
            void'(pixel_expect_q.pop_front());
        end
        if (mismatch_count == 0)
            $display("line_pixel_rasterizer verification clean");
        else
            $display("line_pixel_rasterizer verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("line_pixel_rasterizer verification failed");
        $finish;
    end

endmodule

### filelist.f
src/lpr_pkg.sv
src/lpr_front.sv
src/lpr_walker.sv
src/line_pixel_rasterizer.sv
tb/sv/tb_line_pixel_rasterizer.sv
